>>> hw/rtl/atep_pkg.sv
// Shared types, character codes and color tables for the terminal escape parser.
package atep_pkg;

	// Parser states
	typedef enum logic [1:0] {
		PS_TEXT = 2'd0,
		PS_ESC  = 2'd1,
		PS_CSI  = 2'd2
	} atep_parse_t;

	// Register indexes on the configuration port
	localparam logic CFG_TEXT_COLUMNS = 1'b0;
	localparam logic CFG_TEXT_ROWS    = 1'b1;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET = 7'd30;

	localparam logic [4:0] MAX_PARAM_LEN = 5'd31;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_RETURN   = 8'h0D;
	localparam logic [7:0] CH_BACKSP   = 8'h08;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_SGR      = 8'h6D;
	localparam logic [7:0] CH_CLEAR    = 8'h4A;
	localparam logic [7:0] CH_HOME     = 8'h48;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	// SGR codes
	localparam logic [7:0] SGR_NORMAL_LO = 8'd30;
	localparam logic [7:0] SGR_NORMAL_HI = 8'd37;
	localparam logic [7:0] SGR_BRIGHT_LO = 8'd90;
	localparam logic [7:0] SGR_BRIGHT_HI = 8'd97;

	localparam logic [31:0] ARGB_WHITE = 32'hFFFFFFFF;
	localparam logic [7:0]  ACC_MAX    = 8'd255;

	// Parser and cursor state carried from byte to byte
	typedef struct packed {
		atep_parse_t parse;
		logic [4:0]  param_len;
		logic [7:0]  param_val;
		logic [7:0]  col;
		logic [6:0]  row;
		logic [31:0] fg;
	} atep_state_t;

	// Result of one byte, without the refresh flag
	typedef struct packed {
		logic        draw;
		logic [6:0]  glyph;
		logic [7:0]  glyph_col;
		logic [6:0]  glyph_row;
		logic [31:0] glyph_color;
		logic        clear;
		logic        scroll;
		logic [7:0]  cursor_col;
		logic [6:0]  cursor_row;
	} atep_result_t;

	function automatic logic [31:0] normal_color(input logic [2:0] idx);
		logic [31:0] c;
		unique case (idx)
			3'd0: c = 32'hFF000000;
			3'd1: c = 32'hFFBB0000;
			3'd2: c = 32'hFF00BB00;
			3'd3: c = 32'hFFBBBB00;
			3'd4: c = 32'hFF0000BB;
			3'd5: c = 32'hFFBB00BB;
			3'd6: c = 32'hFF00BBBB;
			default: c = 32'hFFBBBBBB;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] bright_color(input logic [2:0] idx);
		logic [31:0] c;
		unique case (idx)
			3'd0: c = 32'hFF555555;
			3'd1: c = 32'hFFFF5555;
			3'd2: c = 32'hFF55FF55;
			3'd3: c = 32'hFFFFFF55;
			3'd4: c = 32'hFF5555FF;
			3'd5: c = 32'hFFFF55FF;
			3'd6: c = 32'hFF55FFFF;
			default: c = 32'hFFFFFFFF;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/atep_step.sv
// Per-byte parse, SGR, cursor, wrap and scroll logic for the terminal escape parser.
module atep_step (
	input  logic [7:0]           char_in,
	input  logic [7:0]           cols,
	input  logic [6:0]           rows,
	input  atep_pkg::atep_state_t cur,
	output atep_pkg::atep_state_t nxt,
	output atep_pkg::atep_result_t res
);
	import atep_pkg::*;

	atep_parse_t parse_n;
	logic        is_letter;
	logic        is_digit;
	logic [11:0] acc_sum;
	logic [8:0]  col_w;
	logic [7:0]  row_w;
	logic [7:0]  row_fix;
	logic        scroll;

	assign is_letter = (char_in >= 8'h61 && char_in <= 8'h7A) ||
		(char_in >= 8'h41 && char_in <= 8'h5A);
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign acc_sum = {4'd0, cur.param_val} * 12'd10 + {8'd0, char_in[3:0]};

	// Parser next state
	always_comb begin
		parse_n = cur.parse;
		unique case (cur.parse)
			PS_TEXT: begin
				if (char_in == CH_ESC) parse_n = PS_ESC;
			end
			PS_ESC: begin
				parse_n = (char_in == CH_LBRACKET) ? PS_CSI : PS_TEXT;
			end
			PS_CSI: begin
				if (is_letter || cur.param_len >= MAX_PARAM_LEN) parse_n = PS_TEXT;
			end
			default: parse_n = PS_TEXT;
		endcase
	end

	// Parameter, color, cursor and glyph updates, then wrap and scroll
	always_comb begin
		nxt.parse       = parse_n;
		nxt.param_len   = cur.param_len;
		nxt.param_val   = cur.param_val;
		nxt.fg          = cur.fg;
		col_w           = {1'b0, cur.col};
		row_w           = {1'b0, cur.row};
		res.draw        = 1'b0;
		res.glyph       = '0;
		res.glyph_col   = '0;
		res.glyph_row   = '0;
		res.glyph_color = '0;
		res.clear       = 1'b0;
		unique case (cur.parse)
			PS_TEXT: begin
				if (char_in == CH_ESC) begin
					nxt.param_len = '0;
					nxt.param_val = '0;
				end else if (char_in == CH_NEWLINE) begin
					col_w = '0;
					row_w = row_w + 8'd1;
				end else if (char_in == CH_RETURN) begin
					col_w = '0;
				end else if (char_in == CH_BACKSP || char_in == CH_DEL) begin
					if (cur.col != 8'd0) col_w = col_w - 9'd1;
				end else if (char_in >= CH_SPACE && char_in < CH_DEL) begin
					res.draw        = 1'b1;
					res.glyph       = char_in[6:0];
					res.glyph_col   = cur.col;
					res.glyph_row   = cur.row;
					res.glyph_color = cur.fg;
					col_w           = col_w + 9'd1;
				end
			end
			PS_CSI: begin
				if (is_letter) begin
					if (char_in == CH_SGR) begin
						if (cur.param_len == 5'd0 || cur.param_val == 8'd0)
							nxt.fg = ARGB_WHITE;
						else if (cur.param_val >= SGR_NORMAL_LO &&
							cur.param_val <= SGR_NORMAL_HI)
							nxt.fg = normal_color(3'(cur.param_val - SGR_NORMAL_LO));
						else if (cur.param_val >= SGR_BRIGHT_LO &&
							cur.param_val <= SGR_BRIGHT_HI)
							nxt.fg = bright_color(3'(cur.param_val - SGR_BRIGHT_LO));
					end else if (char_in == CH_CLEAR) begin
						res.clear = 1'b1;
						col_w     = '0;
						row_w     = '0;
					end else if (char_in == CH_HOME) begin
						col_w = '0;
						row_w = '0;
					end
				end else if (cur.param_len < MAX_PARAM_LEN) begin
					nxt.param_len = cur.param_len + 5'd1;
					if (is_digit)
						nxt.param_val = (acc_sum > 12'(ACC_MAX)) ? ACC_MAX : acc_sum[7:0];
				end
			end
			default: ;
		endcase

		// Wrap at the column limit, then scroll at the row limit
		row_fix = row_w;
		nxt.col = col_w[7:0];
		if (col_w >= {1'b0, cols}) begin
			nxt.col = '0;
			row_fix = row_w + 8'd1;
		end
		scroll         = (row_fix >= {1'b0, rows});
		nxt.row        = scroll ? (rows - 7'd1) : row_fix[6:0];
		res.scroll     = scroll;
		res.cursor_col = nxt.col;
		res.cursor_row = nxt.row;
	end

endmodule

>>> hw/rtl/ansi_terminal_escape_parser.sv
// Top level of the terminal escape parser: byte register, state, result register, config.
//
//   channel | direction | handshake            | payload
//   in      | to block  | in_valid / in_ready   | char_in, last_byte
//   out     | from blk  | out_valid / out_ready | draw_glyph .. refresh
//   cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while results are taken; each byte passes the byte register, then the result register.
// The byte register feeds the parse and cursor logic, which updates the state
// registers and loads the result register in the same cycle.
// Reset returns the parser to text, the cursor home, the color white and the
// geometry to 80 by 30. A stalled result holds; the byte register advances
// into it in the cycle the result is taken.
module ansi_terminal_escape_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        draw_glyph,
	output logic [6:0]  glyph,
	output logic [7:0]  glyph_col,
	output logic [6:0]  glyph_row,
	output logic [31:0] glyph_color,
	output logic        clear_screen,
	output logic        scroll_up,
	output logic [7:0]  cursor_col_out,
	output logic [6:0]  cursor_row_out,
	output logic        refresh,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import atep_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         advance;
	logic [7:0]   cols_q;
	logic [6:0]   rows_q;
	logic [7:0]   cols_eff;
	logic [6:0]   rows_eff;
	atep_state_t  state_q;
	atep_state_t  state_n;
	atep_result_t res_n;
	atep_result_t res_s2;
	logic         last_s2;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Treat a zero geometry register as one
	assign cols_eff = (cols_q == 8'd0) ? 8'd1 : cols_q;
	assign rows_eff = (rows_q == 7'd0) ? 7'd1 : rows_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TEXT_COLUMNS: cols_q <= cfg_data;
				CFG_TEXT_ROWS:    rows_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Byte register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte register: payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			last_s1 <= last_byte;
		end
	end

	atep_step u_step (
		.char_in (char_s1),
		.cols    (cols_eff),
		.rows    (rows_eff),
		.cur     (state_q),
		.nxt     (state_n),
		.res     (res_n)
	);

	// Parser and cursor state: advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.parse     <= PS_TEXT;
			state_q.param_len <= '0;
			state_q.param_val <= '0;
			state_q.col       <= '0;
			state_q.row       <= '0;
			state_q.fg        <= ARGB_WHITE;
		end else if (advance) begin
			state_q <= state_n;
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= res_n;
			last_s2 <= last_s1;
		end
	end

	assign draw_glyph     = res_s2.draw;
	assign glyph          = res_s2.glyph;
	assign glyph_col      = res_s2.glyph_col;
	assign glyph_row      = res_s2.glyph_row;
	assign glyph_color    = res_s2.glyph_color;
	assign clear_screen   = res_s2.clear;
	assign scroll_up      = res_s2.scroll;
	assign cursor_col_out = res_s2.cursor_col;
	assign cursor_row_out = res_s2.cursor_row;
	assign refresh        = last_s2;

`ifndef SYNTHESIS
	a_glyph_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && draw_glyph |-> glyph >= 7'd32 && glyph != 7'd127)
		else $error("drawn glyph is not printable");

	a_no_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !draw_glyph |-> glyph == 7'd0 && glyph_color == 32'd0 &&
			glyph_col == 8'd0 && glyph_row == 7'd0)
		else $error("glyph fields set without a draw");

	a_cursor_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_col_out < cols_eff && cursor_row_out < rows_eff)
		else $error("cursor outside the window");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clear_screen |-> cursor_col_out == 8'd0 &&
			cursor_row_out == 7'd0 && !draw_glyph)
		else $error("clear did not home the cursor");
`endif

endmodule

>>> tb/atep_stream_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the terminal escape parser: predicts every result and compares it.
module atep_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        draw_glyph,
	input  logic [6:0]  glyph,
	input  logic [7:0]  glyph_col,
	input  logic [6:0]  glyph_row,
	input  logic [31:0] glyph_color,
	input  logic        clear_screen,
	input  logic        scroll_up,
	input  logic [7:0]  cursor_col_out,
	input  logic [6:0]  cursor_row_out,
	input  logic        refresh,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          glyphs_drawn,
	output int          scrolls_seen,
	output int          clears_seen
);
	import atep_pkg::*;

	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_Z = "Z";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_Z = "z";

	// One byte's worth of terminal output
	typedef struct packed {
		logic        draw;
		logic [6:0]  code;
		logic [7:0]  at_col;
		logic [6:0]  at_row;
		logic [31:0] tone;
		logic        clear_req;
		logic        scroll_req;
		logic [7:0]  cursor_col;
		logic [6:0]  cursor_row;
		logic        refresh_req;
	} glyph_step_t;

	// Predicted terminal state and geometry
	atep_parse_t parse_mode    = PS_TEXT;
	int          param_count   = 0;
	int          digit_acc     = 0;
	int          cur_col       = 0;
	int          cur_row       = 0;
	logic [31:0] fg_tone       = ARGB_WHITE;
	int          cols_setting  = COLS_RESET;
	int          rows_setting  = ROWS_RESET;

	glyph_step_t expected_steps[$];
	glyph_step_t seen;
	glyph_step_t want;

	initial begin
		mismatches   = 0;
		pending      = 0;
		checked      = 0;
		glyphs_drawn = 0;
		scrolls_seen = 0;
		clears_seen  = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [31:0] palette_tone(input bit bright, input int idx);
		logic [31:0] tone;
		case (idx[2:0])
			3'd0: tone = bright ? 32'hFF555555 : 32'hFF000000;
			3'd1: tone = bright ? 32'hFFFF5555 : 32'hFFBB0000;
			3'd2: tone = bright ? 32'hFF55FF55 : 32'hFF00BB00;
			3'd3: tone = bright ? 32'hFFFFFF55 : 32'hFFBBBB00;
			3'd4: tone = bright ? 32'hFF5555FF : 32'hFF0000BB;
			3'd5: tone = bright ? 32'hFFFF55FF : 32'hFFBB00BB;
			3'd6: tone = bright ? 32'hFF55FFFF : 32'hFF00BBBB;
			default: tone = bright ? 32'hFFFFFFFF : 32'hFFBBBBBB;
		endcase
		return tone;
	endfunction

	// Advance the predicted terminal by one byte and return what it should emit
	function automatic glyph_step_t advance_terminal(input logic [7:0] c, input logic last);
		glyph_step_t step;
		int          ncols;
		int          nrows;
		bit          is_letter;
		step      = '0;
		ncols     = (cols_setting == 0) ? 1 : cols_setting;
		nrows     = (rows_setting == 0) ? 1 : rows_setting;
		is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
			(c >= CH_LOWER_A && c <= CH_LOWER_Z);
		case (parse_mode)
			PS_ESC: begin
				parse_mode = (c == CH_LBRACKET) ? PS_CSI : PS_TEXT;
			end
			PS_CSI: begin
				if (is_letter) begin
					if (c == CH_SGR) begin
						if (param_count == 0 || digit_acc == 0) begin
							fg_tone = ARGB_WHITE;
						end else if (digit_acc >= int'(SGR_NORMAL_LO) &&
							digit_acc <= int'(SGR_NORMAL_HI)) begin
							fg_tone = palette_tone(1'b0, digit_acc - int'(SGR_NORMAL_LO));
						end else if (digit_acc >= int'(SGR_BRIGHT_LO) &&
							digit_acc <= int'(SGR_BRIGHT_HI)) begin
							fg_tone = palette_tone(1'b1, digit_acc - int'(SGR_BRIGHT_LO));
						end
					end else if (c == CH_CLEAR) begin
						step.clear_req = 1'b1;
						cur_col = 0;
						cur_row = 0;
					end else if (c == CH_HOME) begin
						cur_col = 0;
						cur_row = 0;
					end
					parse_mode = PS_TEXT;
				end else if (param_count < int'(MAX_PARAM_LEN)) begin
					param_count++;
					if (c >= CH_ZERO && c <= CH_NINE) begin
						digit_acc = digit_acc * 10 + (int'(c) - int'(CH_ZERO));
						if (digit_acc > int'(ACC_MAX))
							digit_acc = int'(ACC_MAX);
					end
				end else begin
					// too many parameter bytes: abandon the sequence
					parse_mode = PS_TEXT;
				end
			end
			default: begin
				if (c == CH_ESC) begin
					parse_mode  = PS_ESC;
					param_count = 0;
					digit_acc   = 0;
				end else if (c == CH_NEWLINE) begin
					cur_col = 0;
					cur_row++;
				end else if (c == CH_RETURN) begin
					cur_col = 0;
				end else if (c == CH_BACKSP || c == CH_DEL) begin
					if (cur_col > 0)
						cur_col--;
				end else if (c >= CH_SPACE && c < CH_DEL) begin
					step.draw   = 1'b1;
					step.code   = c[6:0];
					step.at_col = cur_col[7:0];
					step.at_row = cur_row[6:0];
					step.tone   = fg_tone;
					cur_col++;
				end
			end
		endcase
		// wrap and scroll after every byte, whatever the parse state
		if (cur_col >= ncols) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= nrows) begin
			step.scroll_req = 1'b1;
			cur_row = nrows - 1;
		end
		step.cursor_col  = cur_col[7:0];
		step.cursor_row  = cur_row[6:0];
		step.refresh_req = last;
		return step;
	endfunction

	// Compare results, track geometry writes, predict accepted bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode   = PS_TEXT;
			param_count  = 0;
			digit_acc    = 0;
			cur_col      = 0;
			cur_row      = 0;
			fg_tone      = ARGB_WHITE;
			cols_setting = COLS_RESET;
			rows_setting = ROWS_RESET;
			expected_steps.delete();
			pending      = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {draw_glyph, glyph, glyph_col, glyph_row, glyph_color, clear_screen,
					scroll_up, cursor_col_out, cursor_row_out, refresh};
				if (expected_steps.size() == 0) begin
					report_mismatch("result transfer with nothing outstanding");
				end else begin
					want = expected_steps.pop_front();
					if (seen.draw != want.draw)
						report_mismatch($sformatf("draw_glyph got %0d want %0d",
							seen.draw, want.draw));
					if (seen.code != want.code)
						report_mismatch($sformatf("glyph got %0h want %0h",
							seen.code, want.code));
					if (seen.at_col != want.at_col)
						report_mismatch($sformatf("glyph_col got %0d want %0d",
							seen.at_col, want.at_col));
					if (seen.at_row != want.at_row)
						report_mismatch($sformatf("glyph_row got %0d want %0d",
							seen.at_row, want.at_row));
					if (seen.tone != want.tone)
						report_mismatch($sformatf("glyph_color got %08h want %08h",
							seen.tone, want.tone));
					if (seen.clear_req != want.clear_req)
						report_mismatch($sformatf("clear_screen got %0d want %0d",
							seen.clear_req, want.clear_req));
					if (seen.scroll_req != want.scroll_req)
						report_mismatch($sformatf("scroll_up got %0d want %0d",
							seen.scroll_req, want.scroll_req));
					if (seen.cursor_col != want.cursor_col)
						report_mismatch($sformatf("cursor_col_out got %0d want %0d",
							seen.cursor_col, want.cursor_col));
					if (seen.cursor_row != want.cursor_row)
						report_mismatch($sformatf("cursor_row_out got %0d want %0d",
							seen.cursor_row, want.cursor_row));
					if (seen.refresh_req != want.refresh_req)
						report_mismatch($sformatf("refresh got %0d want %0d",
							seen.refresh_req, want.refresh_req));
					checked++;
					if (want.draw)
						glyphs_drawn++;
					if (want.scroll_req)
						scrolls_seen++;
					if (want.clear_req)
						clears_seen++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TEXT_COLUMNS)
					cols_setting = cfg_data;
				else
					rows_setting = cfg_data[6:0];
			end
			if (in_valid && in_ready)
				expected_steps.push_back(advance_terminal(char_in, last_byte));
			pending = expected_steps.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the terminal escape parser.
module tb_top;
	import atep_pkg::*;

	localparam int         HOLD_CYCLES    = 200;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam logic [7:0] CH_TILDE       = 8'h7E;
	localparam logic [7:0] CH_SEMICOLON   = ";";
	localparam logic [7:0] CH_QUESTION    = "?";

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  char_in        = 8'h00;
	logic        last_byte      = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic        draw_glyph;
	logic [6:0]  glyph;
	logic [7:0]  glyph_col;
	logic [6:0]  glyph_row;
	logic [31:0] glyph_color;
	logic        clear_screen;
	logic        scroll_up;
	logic [7:0]  cursor_col_out;
	logic [6:0]  cursor_row_out;
	logic        refresh;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic        cfg_index      = 1'b0;
	logic [7:0]  cfg_data       = 8'h00;

	int mismatches;
	int pending;
	int checked;
	int glyphs_drawn;
	int scrolls_seen;
	int clears_seen;

	int bytes_sent     = 0;
	int geometries     = 1;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	ansi_terminal_escape_parser u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_in        (char_in),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.draw_glyph     (draw_glyph),
		.glyph          (glyph),
		.glyph_col      (glyph_col),
		.glyph_row      (glyph_row),
		.glyph_color    (glyph_color),
		.clear_screen   (clear_screen),
		.scroll_up      (scroll_up),
		.cursor_col_out (cursor_col_out),
		.cursor_row_out (cursor_row_out),
		.refresh        (refresh),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	atep_stream_checker u_checker (.*);

	always #5 clk = ~clk;

	// Receiver: random stalls, plus a long hold-off whenever one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_served < hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: give up after a long stretch with no transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit rand_last();
		return ($urandom_range(0, 7) == 0);
	endfunction

	function automatic logic [7:0] printable_byte();
		return 8'($urandom_range(CH_SPACE, CH_TILDE));
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1) == 1)
			return 8'("A" + $urandom_range(0, 25));
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	// Final byte of a control sequence, weighted toward the handled commands
	function automatic logic [7:0] csi_final();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return CH_SGR;
			4: return CH_CLEAR;
			5: return CH_HOME;
			default: return random_letter();
		endcase
	endfunction

	// Non-letter byte inside a sequence
	function automatic logic [7:0] param_byte();
		case ($urandom_range(0, 5))
			0, 1, 2: return 8'(CH_ZERO + $urandom_range(0, 9));
			3: return CH_SEMICOLON;
			4: return 8'($urandom_range(128, 255));
			default: return CH_QUESTION;
		endcase
	endfunction

	// Offer one byte and hold it until the transfer
	task automatic send_byte(input logic [7:0] c, input logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_in   <= c;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], rand_last());
	endtask

	// Drop valid and wait until every result has been taken
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random unit: mostly text and well-formed sequences, some noise
	task automatic send_random_unit();
		int    pick;
		string params;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_byte(printable_byte(), rand_last());
		end else if (pick < 62) begin
			send_byte(CH_ESC, rand_last());
			send_byte(CH_LBRACKET, rand_last());
			case ($urandom_range(0, 4))
				0: params = ($urandom_range(0, 1) == 1) ? "" : "0";
				1: params = $sformatf("%0d", $urandom_range(SGR_NORMAL_LO, SGR_NORMAL_HI));
				2: params = $sformatf("%0d", $urandom_range(SGR_BRIGHT_LO, SGR_BRIGHT_HI));
				3: params = $sformatf("%0d", $urandom_range(0, 999));
				default: params = $sformatf("%0d;%0d", $urandom_range(0, 9),
					$urandom_range(0, 120));
			endcase
			send_text(params);
			send_byte(csi_final(), rand_last());
		end else if (pick < 72) begin
			case ($urandom_range(0, 3))
				0: send_byte(CH_NEWLINE, rand_last());
				1: send_byte(CH_RETURN, rand_last());
				2: send_byte(CH_BACKSP, rand_last());
				default: send_byte(CH_DEL, rand_last());
			endcase
		end else if (pick < 77) begin
			send_byte(8'($urandom_range(128, 255)), rand_last());
		end else if (pick < 82) begin
			send_byte(CH_ESC, rand_last());
			send_byte(8'($urandom_range(0, 255)), rand_last());
		end else if (pick < 85) begin
			// parameter run around the length limit
			send_byte(CH_ESC, rand_last());
			send_byte(CH_LBRACKET, rand_last());
			repeat ($urandom_range(28, 34))
				send_byte(param_byte(), rand_last());
			if ($urandom_range(0, 1) == 1)
				send_byte(csi_final(), rand_last());
			else
				send_byte(8'($urandom_range(0, 255)), rand_last());
		end else begin
			send_byte(8'($urandom_range(0, 255)), rand_last());
		end
	endtask

	// Set the geometry and flow profile, then stream random traffic
	task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows_data,
		input int idle_pct, input int stall_pct, input int units,
		input bit long_line, input bit squeeze);
		int target;
		settle();
		write_register(CFG_TEXT_COLUMNS, cols);
		write_register(CFG_TEXT_ROWS, rows_data);
		geometries++;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		if (squeeze)
			hold_requests++;
		if (long_line) begin
			repeat (260)
				send_byte(printable_byte(), rand_last());
		end
		target = bytes_sent + units;
		while (bytes_sent < target)
			send_random_unit();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of text, colors, controls and sequence corner cases
		send_text("A ~");
		send_byte(CH_ESC, 1'b0);
		send_text("[31m");
		send_byte("x", 1'b1);
		send_byte(CH_ESC, 1'b0);
		send_text("[999m");
		send_byte(CH_ESC, 1'b0);
		send_text("[m");
		send_byte(CH_ESC, 1'b1);
		send_byte("Q", 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_RETURN, 1'b1);
		send_byte(CH_BACKSP, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_ESC, 1'b0);
		send_text("[J");

		// Random phases over geometries and flow profiles
		run_phase(8'd8,   8'd4,   0,  0,  110, 1'b0, 1'b1);
		run_phase(8'd0,   8'd0,   0,  84, 90,  1'b0, 1'b0);
		run_phase(8'd1,   8'd127, 20, 20, 90,  1'b0, 1'b0);
		run_phase(8'd255, 8'h85,  84, 0,  60,  1'b1, 1'b0);
		run_phase(8'd40,  8'd1,   0,  84, 90,  1'b0, 1'b0);
		run_phase(8'd80,  8'd30,  20, 20, 100, 1'b0, 1'b0);

		settle();
		repeat (8) @(negedge clk);
		$display("summary: %0d bytes over %0d geometry settings, %0d results checked",
			bytes_sent, geometries, checked);
		$display("summary: %0d glyphs, %0d scrolls, %0d clears, %0d mismatches",
			glyphs_drawn, scrolls_seen, clears_seen, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
